FILE: sv/cbs_pkg.sv
package cbs_pkg;

	localparam int unsigned WORD_WIDTH_DEF  = 64;
	localparam int unsigned CLASS_WIDTH_DEF = 8;
	localparam int unsigned COUNT_WIDTH_DEF = 20;

	localparam int unsigned IN_WORD_W   = 64;
	localparam int unsigned ATTR_W      = 16;
	localparam int unsigned CBITS_W     = 4;
	localparam int unsigned OBS_W       = 20;
	localparam int unsigned LABEL_W     = 8;
	localparam int unsigned SLOT_W      = 28;
	localparam int unsigned LINE_W      = 20;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ATTRIBUTE_COUNT   = 2'd0,
		REG_CLASS_BIT_COUNT   = 2'd1,
		REG_OBSERVATION_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [IN_WORD_W-1:0] line_word;
		logic                 end_of_line;
	} item_t;

	typedef struct packed {
		logic [LABEL_W-1:0] class_label;
		logic [SLOT_W-1:0]  bucket_slot;
		logic [LINE_W-1:0]  line_number;
	} result_t;

endpackage

FILE: sv/class_bucket_scatter.sv
// An accepted end-of-line beat passes through stage 1, stage 2 and the result queue before its result is on the output.
// Throughput: one word per cycle while item_ready is high; the count table is read at acceptance
// and written back in the next cycle, with forwarding between back-to-back lines of one class.
// A write to attribute_count holds the input while the word offset settles.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all 2**CLASS_WIDTH
// entries of the count table, during which no word is accepted.
module class_bucket_scatter
	import cbs_pkg::*;
#(
	parameter int unsigned WORD_WIDTH  = WORD_WIDTH_DEF,
	parameter int unsigned CLASS_WIDTH = CLASS_WIDTH_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned RW        = $clog2(WORD_WIDTH);
	localparam int unsigned SW        = RW + 2;
	localparam int unsigned CB_LIM    = (CLASS_WIDTH < WORD_WIDTH) ? CLASS_WIDTH : WORD_WIDTH;
	localparam int unsigned RCP_SHIFT = ATTR_W + RW + 1;
	localparam logic [RCP_SHIFT:0] RCP =
		(RCP_SHIFT+1)'(((2 ** RCP_SHIFT) + WORD_WIDTH - 1) / WORD_WIDTH);
	localparam int unsigned CLS_DEPTH = 2 ** CLASS_WIDTH;
	localparam int unsigned PROD_W    = CLASS_WIDTH + OBS_W;

	// configuration
	logic [ATTR_W-1:0]  attr_q;
	logic [CBITS_W-1:0] cbc_q;
	logic [OBS_W-1:0]   obs_q;
	logic [1:0]         pend_q;
	logic [ATTR_W-1:0]  quot_q;
	logic [RW-1:0]      rem_q;

	logic [ATTR_W+RCP_SHIFT:0] rcp_prod;
	logic [ATTR_W+RW:0]        back_prod;
	logic [ATTR_W-1:0]         rem_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= '0;
			cbc_q  <= CBITS_W'(1);
			obs_q  <= OBS_W'(1);
			pend_q <= '0;
		end else begin
			pend_q <= {1'b0, pend_q[1]};
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ATTRIBUTE_COUNT: begin
						attr_q <= cfg_data[ATTR_W-1:0];
						pend_q <= 2'b11;
					end
					REG_CLASS_BIT_COUNT:   cbc_q <= cfg_data[CBITS_W-1:0];
					REG_OBSERVATION_COUNT: obs_q <= cfg_data[OBS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// word offset: attribute_count mod WORD_WIDTH by reciprocal
	assign rcp_prod  = (ATTR_W+RCP_SHIFT+1)'(attr_q) * (ATTR_W+RCP_SHIFT+1)'(RCP);
	assign back_prod = (ATTR_W+RW+1)'(quot_q) * (ATTR_W+RW+1)'(WORD_WIDTH);
	assign rem_full  = attr_q - back_prod[ATTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q  <= '0;
		end else begin
			quot_q <= rcp_prod[RCP_SHIFT +: ATTR_W];
			if (rem_full >= ATTR_W'(WORD_WIDTH)) begin
				rem_q <= RW'(rem_full - ATTR_W'(WORD_WIDTH));
			end else begin
				rem_q <= RW'(rem_full);
			end
		end
	end

	// word stream and class extraction
	logic [WORD_WIDTH-1:0]   prev_q;
	logic [LINE_W-1:0]       line_q;
	logic [WORD_WIDTH-1:0]   word;
	logic [CBITS_W-1:0]      cb_eff;
	logic [SW-1:0]           bit_sum;
	logic [SW-1:0]           pos;
	logic [2*WORD_WIDTH-1:0] shifted;
	logic [CLASS_WIDTH-1:0]  cls_mask;
	logic [CLASS_WIDTH-1:0]  cls0;
	logic                    accept;
	logic                    line_end;

	assign word     = item.line_word[WORD_WIDTH-1:0];
	assign accept   = item_valid && item_ready;
	assign line_end = accept && item.end_of_line;

	always_comb begin
		cb_eff  = (cbc_q > CBITS_W'(CB_LIM)) ? CBITS_W'(CB_LIM) : cbc_q;
		bit_sum = SW'(rem_q) + SW'(cb_eff);
		if (bit_sum > SW'(WORD_WIDTH)) begin
			pos = SW'(2 * WORD_WIDTH) - bit_sum;
		end else begin
			pos = SW'(WORD_WIDTH) - bit_sum;
		end
		shifted = {prev_q, word} >> pos;
		for (int i = 0; i < CLASS_WIDTH; i++) begin
			cls_mask[i] = (CBITS_W'(i) < cb_eff);
		end
		cls0 = shifted[CLASS_WIDTH-1:0] & cls_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			line_q <= '0;
		end else if (accept) begin
			prev_q <= word;
			if (item.end_of_line) begin
				line_q <= line_q + 1'b1;
			end
		end
	end

	// count table: read at acceptance, written back in stage 1
	logic [COUNT_WIDTH-1:0] count_mem [CLS_DEPTH];
	logic                   clearing_q;
	logic [CLASS_WIDTH-1:0] clr_q;

	logic                   v_s1;
	logic [CLASS_WIDTH-1:0] cls_s1;
	logic [LINE_W-1:0]      line_s1;
	logic [COUNT_WIDTH-1:0] rd_s1;

	logic                   v_s2;
	logic [CLASS_WIDTH-1:0] cls_s2;
	logic [LINE_W-1:0]      line_s2;
	logic [COUNT_WIDTH-1:0] cnt_s2;
	logic [COUNT_WIDTH-1:0] newcnt_s2;
	logic [PROD_W-1:0]      prod_s2;

	logic [COUNT_WIDTH-1:0] cnt_s1;
	logic [COUNT_WIDTH-1:0] newcnt_s1;
	logic                   mem_we;
	logic [CLASS_WIDTH-1:0] mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;

	always_comb begin
		cnt_s1    = (v_s2 && (cls_s2 == cls_s1)) ? newcnt_s2 : rd_s1;
		newcnt_s1 = (cnt_s1 == '1) ? cnt_s1 : cnt_s1 + 1'b1;
		mem_we    = clearing_q || v_s1;
		mem_waddr = clearing_q ? clr_q : cls_s1;
		mem_wdata = clearing_q ? '0 : newcnt_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= count_mem[cls0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= line_end;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1    <= cls0;
		line_s1   <= line_q;
		cls_s2    <= cls_s1;
		line_s2   <= line_s1;
		cnt_s2    <= cnt_s1;
		newcnt_s2 <= newcnt_s1;
		prod_s2   <= PROD_W'(cls_s1) * PROD_W'(obs_q);
	end

	// result queue
	result_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_PTR_W:0]    cnt_q;
	logic [FIFO_PTR_W:0]    inflight;
	logic                   push;
	logic                   pop;
	result_t                push_data;

	assign push = v_s2;
	assign pop  = result_valid && result_ready;

	always_comb begin
		push_data.class_label = LABEL_W'(cls_s2);
		push_data.bucket_slot = SLOT_W'(prod_s2) + SLOT_W'(cnt_s2);
		push_data.line_number = line_s2;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign result_valid = (cnt_q != '0);
	assign result       = fifo_q[rd_ptr_q];

	// hold input while the table clears, the offset settles or queue credit runs out
	assign inflight   = cnt_q + (FIFO_PTR_W+1)'(v_s1) + (FIFO_PTR_W+1)'(v_s2);
	assign item_ready = !clearing_q && (pend_q == '0)
		&& (inflight < (FIFO_PTR_W+1)'(FIFO_DEPTH));

`ifndef ASSERT_OFF
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		inflight <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
		else $error("result queue credit exceeded");

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s1 && !v_s2 && !item_ready)
		else $error("item in flight during table clear");

	a_offset_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) |-> !item_ready)
		else $error("word accepted before offset settled");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (newcnt_s2 == cnt_s2 + 1'b1) || ((cnt_s2 == '1) && (newcnt_s2 == cnt_s2)))
		else $error("class count not incremented or saturated");

	a_line_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && $past(v_s1) |-> line_s1 == $past(line_s1) + 1'b1)
		else $error("line numbers out of order");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
	import cbs_pkg::*;

	localparam int unsigned WW            = WORD_WIDTH_DEF;
	localparam int unsigned WORD_TARGET   = 1050;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_AFTER    = 150;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam longint unsigned RUN_LIMIT = 64'd20_000_000;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = '1;

	typedef struct {
		result_t         res;
		longint unsigned stamp;
	} slot_entry_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_ready;
	item_t                  item         = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	item_t       word_queue[$];
	slot_entry_t slot_queue[$];
	int unsigned words_pushed = 0;

	logic [ATTR_W-1:0]  attr_count = '0;
	logic [CBITS_W-1:0] label_bits = CBITS_W'(1);
	logic [OBS_W-1:0]   obs_stride = OBS_W'(1);

	logic [WW-1:0]              prev_word  = '0;
	logic [LINE_W-1:0]          line_count = '0;
	logic [COUNT_WIDTH_DEF-1:0] class_tally [1 << CLASS_WIDTH_DEF] = '{default: '0};

	bit          send_steady = 1'b0;
	bit          recv_steady = 1'b0;
	int unsigned send_gap    = 0;
	int unsigned recv_wait   = 0;
	int unsigned hold_left   = 0;
	bit          hold_done   = 1'b0;
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;

	class_bucket_scatter DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned pick_gap(bit steady);
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		if (r < 98) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [WW-1:0] rand_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void push_word(logic [WW-1:0] w, bit eol);
		item_t beat;
		beat.line_word = w;
		beat.end_of_line = eol;
		word_queue.push_back(beat);
		words_pushed++;
	endfunction

	function automatic logic [LABEL_W-1:0] label_of(logic [WW-1:0] w);
		int unsigned rem, width, in_prev, in_last;
		logic [WW-1:0] field;
		rem = attr_count % WW;
		width = (label_bits > CLASS_WIDTH_DEF) ? CLASS_WIDTH_DEF : label_bits;
		if (width == 0) return '0;
		if (rem + width <= WW) begin
			field = (w >> (WW - rem - width)) & ((64'd1 << width) - 1);
			return field[LABEL_W-1:0];
		end
		in_prev = WW - rem;
		in_last = width - in_prev;
		field = ((prev_word & ((64'd1 << in_prev) - 1)) << in_last) | (w >> (WW - in_last));
		return field[LABEL_W-1:0];
	endfunction

	function automatic void take_word(item_t beat);
		logic [LABEL_W-1:0] cls;
		logic [63:0]        slot;
		slot_entry_t        entry;
		if (beat.end_of_line) begin
			cls = label_of(beat.line_word);
			slot = cls * obs_stride + class_tally[cls];
			entry.res.class_label = cls;
			entry.res.bucket_slot = slot[SLOT_W-1:0];
			entry.res.line_number = line_count;
			entry.stamp = $time;
			slot_queue.push_back(entry);
			if (class_tally[cls] != '1) class_tally[cls] = class_tally[cls] + 1'b1;
			line_count = line_count + 1'b1;
		end
		prev_word = beat.line_word;
	endfunction

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ATTRIBUTE_COUNT: attr_count = data[ATTR_W-1:0];
			REG_CLASS_BIT_COUNT: label_bits = data[CBITS_W-1:0];
			REG_OBSERVATION_COUNT: obs_stride = data[OBS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic settle();
		while (word_queue.size() != 0 || item_valid || slot_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		logic take;
		take = item_valid && item_ready;
		if (take) begin
			take_word(item);
			send_gap = pick_gap(send_steady);
			if ($urandom_range(40) == 0) send_steady = !send_steady;
		end
		if (!item_valid || take) begin
			if (send_gap == 0 && word_queue.size() != 0) begin
				item <= word_queue.pop_front();
				item_valid <= 1'b1;
			end else begin
				if (send_gap != 0) send_gap--;
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		logic        took;
		slot_entry_t want;
		took = result_valid && result_ready;
		if (took) begin
			results_seen++;
			if (slot_queue.size() == 0 || slot_queue[0].stamp >= $time) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: label %0d slot %0d line %0d",
						result.class_label, result.bucket_slot, result.line_number);
			end else begin
				want = slot_queue.pop_front();
				if (result.class_label !== want.res.class_label ||
						result.bucket_slot !== want.res.bucket_slot ||
						result.line_number !== want.res.line_number) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: want label %0d slot %0d line %0d, got label %0d slot %0d line %0d",
							want.res.class_label, want.res.bucket_slot, want.res.line_number,
							result.class_label, result.bucket_slot, result.line_number);
				end
			end
			if (!hold_done && results_seen >= HOLD_AFTER && word_queue.size() > 20) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				recv_wait = pick_gap(recv_steady);
			end
			if ($urandom_range(40) == 0) recv_steady = !recv_steady;
		end else if (!result_valid && recv_wait == 0 && hold_left == 0 &&
				$urandom_range(15) == 0) begin
			recv_wait = pick_gap(recv_steady);
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (recv_wait != 0) begin
			recv_wait--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin
		int unsigned attr, cbits, obs, width, total, sent, pos, cls, phase_end;
		int          k;
		logic [31:0] garbage;
		logic [WW-1:0] words [8];

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		push_word('0, 1'b1);
		push_word('1, 1'b1);
		push_word('1, 1'b0);
		push_word('0, 1'b1);
		push_word({1'b1, {(WW-1){1'b0}}}, 1'b1);
		push_word({1'b0, {(WW-1){1'b1}}}, 1'b1);
		settle();

		// label straddles the word boundary, zero bucket stride
		write_reg(REG_ATTRIBUTE_COUNT, 60);
		write_reg(REG_CLASS_BIT_COUNT, 8);
		write_reg(REG_OBSERVATION_COUNT, 0);
		push_word(64'h0123_4567_89AB_CDEA, 1'b0);
		push_word(64'h5FED_CBA9_8765_4321, 1'b1);
		push_word(64'h0123_4567_89AB_CDEA, 1'b0);
		push_word(64'h5FED_CBA9_8765_4321, 1'b1);
		push_word(64'h3000_0000_0000_0000, 1'b1);
		push_word('1, 1'b0);
		push_word('0, 1'b1);
		settle();

		write_reg(REG_CLASS_BIT_COUNT, 0);
		write_reg(REG_ATTRIBUTE_COUNT, 16'hFFFF);
		write_reg(REG_OBSERVATION_COUNT, 20'hFFFFF);
		push_word('1, 1'b1);
		settle();

		write_reg(REG_CLASS_BIT_COUNT, 15);
		push_word('1, 1'b0);
		push_word('1, 1'b1);
		push_word('0, 1'b1);
		settle();

		write_reg(REG_ATTRIBUTE_COUNT, 56);
		write_reg(REG_SPARE, $urandom);
		push_word(rand_word(), 1'b1);
		push_word(rand_word(), 1'b1);
		settle();

		while (words_pushed < WORD_TARGET) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: attr = $urandom_range(130);
				5, 6: attr = WW * $urandom_range(4, 1) - $urandom_range(8);
				7: attr = $urandom_range(16'hFFFF);
				8: attr = 16'hFFFF - $urandom_range(7);
				default: attr = 0;
			endcase
			cbits = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
			case ($urandom_range(4))
				0: obs = 0;
				1: obs = 1;
				2: obs = 20'hFFFFF;
				3: obs = $urandom_range(1000, 2);
				default: obs = $urandom_range(20'hFFFFF);
			endcase
			garbage = $urandom;
			write_reg(REG_ATTRIBUTE_COUNT, {garbage[31:16], attr[15:0]});
			write_reg(REG_CLASS_BIT_COUNT, {garbage[31:4], cbits[3:0]});
			write_reg(REG_OBSERVATION_COUNT, {garbage[31:20], obs[19:0]});
			width = (cbits > CLASS_WIDTH_DEF) ? CLASS_WIDTH_DEF : cbits;

			phase_end = words_pushed + $urandom_range(110, 50);
			while (words_pushed < phase_end) begin
				if ($urandom_range(99) < 85) begin
					total = (attr + width + WW - 1) / WW;
					if (total == 0) total = 1;
					// long lines: send only their tail
					sent = (total > 6) ? $urandom_range(2, 1) : total;
					for (int i = 0; i < sent; i++) words[i] = rand_word();
					if (width != 0 && $urandom_range(2) != 0) begin
						case ($urandom_range(3))
							0: cls = 0;
							1: cls = (1 << width) - 1;
							default: cls = $urandom_range(3);
						endcase
						for (int i = 0; i < width; i++) begin
							pos = attr + i;
							k = int'(pos / WW) - int'(total - sent);
							if (k >= 0) words[k][WW - 1 - pos % WW] = cls[width - 1 - i];
						end
					end
					for (int i = 0; i < sent; i++) push_word(words[i], i == sent - 1);
				end else begin
					repeat ($urandom_range(4, 1)) push_word(rand_word(), $urandom_range(7) == 0);
				end
			end
			settle();
		end

		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
